/* hw/rtl/dgw_pkg.sv */
// shared constants and types of the dft gaussian weighting block
`timescale 1ns / 1ps

package dgw_pkg;

   // default parameter values
   localparam int DEF_MAX_DIM     = 2048;
   localparam int DEF_SAMPLE_BITS = 24;
   localparam int DEF_WEIGHT_BITS = 16;

   // register port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int GAIN_BITS      = 32;
   localparam int DEF_IMAGE_SIZE = 256;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_ROW_GAIN,
      CSR_COL_GAIN
   } csr_reg_type;

   // exponent in q4.24, cut off at 12.0
   localparam int                X_BITS  = 28;
   localparam int                SQ_BITS = X_BITS + 1;
   localparam logic [X_BITS-1:0] EXP_CUT = 28'hC00_0000;

   // exp approximation constants
   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam int          TAYLOR_TERMS = 7;

   // exp unit: log2 scaling, fraction scaling, three stages per taylor term, final round
   localparam int EXP_LAT = 3 * TAYLOR_TERMS + 3;

   // exponent handed to the exp unit
   typedef struct packed {
      logic              zero;
      logic [X_BITS-1:0] x;
   } exp_in_type;

endpackage

/* hw/rtl/dgw_exp.sv */
// pipelined fixed point exp(-x) unit producing the gaussian weight
`timescale 1ns / 1ps

module dgw_exp #(
   parameter int WEIGHT_BITS = dgw_pkg::DEF_WEIGHT_BITS
) (
   input  logic                    clock,
   input  logic                    enable,
   input  dgw_pkg::exp_in_type     exp_in,
   output logic [WEIGHT_BITS-1:0]  weight
);
   import dgw_pkg::*;

   localparam int FRAC      = WEIGHT_BITS - 1;
   localparam int Y_BITS    = 29;
   localparam int K_BITS    = Y_BITS - 24;
   localparam int U_BITS    = 30;
   localparam int Q_BITS    = 30;
   localparam int P_BITS    = 31;
   localparam int SIDE_LAST = 3 * TAYLOR_TERMS;

   typedef struct packed {
      logic              zero;
      logic [K_BITS-1:0] k;
      logic [U_BITS-1:0] u;
   } side_type;

   logic              zero_y_ff;
   logic [Y_BITS-1:0] y_ff;
   logic [59:0]       y_prod;
   logic [54:0]       u_prod;
   side_type          side_ff [0:SIDE_LAST];
   logic [P_BITS-1:0] p_src   [0:TAYLOR_TERMS];
   logic [P_BITS-1:0] p_ff    [0:TAYLOR_TERMS-1];
   logic [Q_BITS-1:0] q_ff    [0:TAYLOR_TERMS-1];
   logic [Q_BITS-1:0] qb_ff   [0:TAYLOR_TERMS-1];
   logic [Q_BITS-1:0] qe_ff   [0:TAYLOR_TERMS-1];
   logic [5:0]        shift;
   logic [63:0]       rounded;
   logic [WEIGHT_BITS-1:0] weight_in;
   logic [WEIGHT_BITS-1:0] weight_ff;

   // y = x * log2(e) in q.24
   assign y_prod = 60'(exp_in.x) * 60'(LOG2E_Q30) + (60'(1) << 29);

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_y_ff <= exp_in.zero;
         y_ff      <= y_prod[58:30];
      end
   end

   // split into integer power of two and fraction times ln2 in q.30
   assign u_prod = 55'(y_ff[23:0]) * 55'(LN2_Q30) + (55'(1) << 23);

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0].zero <= zero_y_ff;
         side_ff[0].k    <= y_ff[Y_BITS-1:24];
         side_ff[0].u    <= u_prod[53:24];
      end
   end

   assign p_src[0] = Q30_ONE;

   // horner form taylor series for exp(-u), one term per three stages
   for (genvar g = 0; g < TAYLOR_TERMS; g++) begin : g_term
      localparam int          D     = TAYLOR_TERMS - g;
      localparam logic [32:0] RECIP = 33'((64'd1 << 32) / D);

      logic [60:0] prod_a;
      logic [62:0] prod_b;
      logic [32:0] mul_d;
      logic [32:0] rem;
      logic [30:0] quo;

      assign prod_a = 61'(side_ff[3*g].u) * 61'(p_src[g]);
      assign prod_b = 63'(q_ff[g]) * 63'(RECIP);
      assign mul_d  = 33'(qe_ff[g]) * 33'(D);
      assign rem    = 33'(qb_ff[g]) - mul_d;
      // reciprocal estimate is low by at most one
      assign quo    = (rem >= 33'(D)) ? 31'(qe_ff[g]) + 31'd1 : 31'(qe_ff[g]);

      always_ff @(posedge clock) begin
         if (enable) begin
            q_ff[g]          <= prod_a[59:30];
            side_ff[3*g+1]   <= side_ff[3*g];
            qe_ff[g]         <= prod_b[61:32];
            qb_ff[g]         <= q_ff[g];
            side_ff[3*g+2]   <= side_ff[3*g+1];
            p_ff[g]          <= Q30_ONE - quo;
            side_ff[3*g+3]   <= side_ff[3*g+2];
         end
      end

      assign p_src[g+1] = p_ff[g];
   end

   // scale by 2^-k and round to the weight format
   always_comb begin
      shift   = 6'(30 - FRAC) + 6'(side_ff[SIDE_LAST].k);
      rounded = 64'(p_src[TAYLOR_TERMS]) + (64'(1) << (shift - 6'd1));
      if (side_ff[SIDE_LAST].zero) begin
         weight_in = '0;
      end else begin
         weight_in = WEIGHT_BITS'(rounded >> shift);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule

/* hw/rtl/dft_gaussian_weighting_top.sv */
// gaussian weighting of half-spectrum 2d dft coefficients
// fully pipelined: one request per cycle when the response side takes every result
// from request acceptance to rsp_valid: 31 register stages of request, wrap, square,
// gain multiply, exponent sum, the 24-stage exp unit, sample multiply and rounding
// a one-entry input skid takes one more request while a response is held
// reset (synchronous): pipeline empty, width and height 256, both gains 0
`timescale 1ns / 1ps

module dft_gaussian_weighting_top #(
   parameter int MAX_DIM     = dgw_pkg::DEF_MAX_DIM,
   parameter int SAMPLE_BITS = dgw_pkg::DEF_SAMPLE_BITS,
   parameter int WEIGHT_BITS = dgw_pkg::DEF_WEIGHT_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [$clog2(MAX_DIM)-1:0]            req_row_index,
   input  logic [$clog2(MAX_DIM)-1:0]            req_col_index,
   input  logic signed [SAMPLE_BITS-1:0]         req_coef_real,
   input  logic signed [SAMPLE_BITS-1:0]         req_coef_imag,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_real,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_imag,
   // register port
   input  logic                                  csr_write,
   input  logic [dgw_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [dgw_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import dgw_pkg::*;

   localparam int IDX_BITS  = $clog2(MAX_DIM);
   localparam int SIZE_BITS = IDX_BITS + 1;
   localparam int FRQ_BITS  = SIZE_BITS + 1;
   localparam int SQ_FULL   = 2 * SIZE_BITS;
   localparam int GP_BITS   = GAIN_BITS + SQ_BITS;
   localparam int FRAC      = WEIGHT_BITS - 1;
   localparam int PROD_BITS = SAMPLE_BITS + WEIGHT_BITS + 1;
   localparam int W_STAGE   = 4 + EXP_LAT;
   localparam int S_STAGE   = W_STAGE + 1;
   localparam int O_STAGE   = W_STAGE + 2;

   localparam logic [SQ_BITS-1:0] SQ_CLAMP = SQ_BITS'(1) << X_BITS;

   typedef struct packed {
      logic [IDX_BITS-1:0]           row;
      logic [IDX_BITS-1:0]           col;
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
   } coef_type;

   // wrap an index to a signed frequency and return its magnitude
   function automatic logic [SIZE_BITS-1:0] wrap_mag(input logic [IDX_BITS-1:0] idx,
                                                     input logic [SIZE_BITS-1:0] size);
      logic signed [FRQ_BITS-1:0] s;
      logic signed [FRQ_BITS-1:0] thr;
      logic signed [FRQ_BITS-1:0] i;
      logic signed [FRQ_BITS-1:0] f;
      s   = $signed(FRQ_BITS'(size));
      thr = s - (s >>> 1) - $signed(FRQ_BITS'(1));
      i   = $signed(FRQ_BITS'(idx));
      f   = (i > thr) ? i - s : i;
      return f[FRQ_BITS-1] ? SIZE_BITS'(-f) : SIZE_BITS'(f);
   endfunction

   // square saturated just above the cutoff
   function automatic logic [SQ_BITS-1:0] clamp_sq(input logic [SQ_FULL-1:0] sq);
      if (64'(sq) >= 64'(SQ_CLAMP)) begin
         return SQ_CLAMP;
      end
      return SQ_BITS'(sq);
   endfunction

   logic [SIZE_BITS-1:0] image_width_ff;
   logic [SIZE_BITS-1:0] image_height_ff;
   logic [GAIN_BITS-1:0] row_gain_ff;
   logic [GAIN_BITS-1:0] col_gain_ff;

   logic                 enable;
   logic                 req_accept;
   logic                 skid_vld_ff;
   logic                 skid_vld_in;
   req_type              skid_ff;
   req_type              in_ff;
   logic [O_STAGE:0]     vld_ff;
   coef_type             coef_ff [1:W_STAGE];

   logic [SIZE_BITS-1:0] mag_r_ff;
   logic [SIZE_BITS-1:0] mag_c_ff;
   logic [SQ_BITS-1:0]   sq_r_ff;
   logic [SQ_BITS-1:0]   sq_c_ff;
   logic [GP_BITS-1:0]   prod_r_ff;
   logic [GP_BITS-1:0]   prod_c_ff;
   logic [X_BITS:0]      x_sum;
   exp_in_type           exp_in_in;
   exp_in_type           exp_in_ff;
   logic [WEIGHT_BITS-1:0] weight;

   logic signed [PROD_BITS-1:0] v_r_ff;
   logic signed [PROD_BITS-1:0] v_i_ff;
   logic signed [PROD_BITS-1:0] v_r_in;
   logic signed [PROD_BITS-1:0] v_i_in;
   logic signed [PROD_BITS-1:0] w_ext;
   logic signed [SAMPLE_BITS-1:0] out_real_ff;
   logic signed [SAMPLE_BITS-1:0] out_imag_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= SIZE_BITS'(DEF_IMAGE_SIZE);
         image_height_ff <= SIZE_BITS'(DEF_IMAGE_SIZE);
         row_gain_ff     <= '0;
         col_gain_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data[SIZE_BITS-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_data[SIZE_BITS-1:0];
            CSR_ROW_GAIN:     row_gain_ff     <= csr_data[GAIN_BITS-1:0];
            CSR_COL_GAIN:     col_gain_ff     <= csr_data[GAIN_BITS-1:0];
         endcase
      end
   end

   // pipeline advances unless a finished response is held
   assign enable      = !vld_ff[O_STAGE] || !rsp_stall;
   assign req_stall   = skid_vld_ff;
   assign req_accept  = req_valid && !skid_vld_ff;
   assign skid_vld_in = !enable && (skid_vld_ff || req_accept);

   // input skid: absorbs one request while the pipeline is frozen
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!enable && req_accept) begin
         skid_ff <= '{row: req_row_index, col: req_col_index,
                      re: req_coef_real, im: req_coef_imag};
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[O_STAGE-1:0], skid_vld_ff || req_accept};
      end
   end

   // stage 0: request register
   always_ff @(posedge clock) begin
      if (enable) begin
         if (skid_vld_ff) begin
            in_ff <= skid_ff;
         end else begin
            in_ff <= '{row: req_row_index, col: req_col_index,
                       re: req_coef_real, im: req_coef_imag};
         end
      end
   end

   // coefficient delay line up to the weight
   always_ff @(posedge clock) begin
      if (enable) begin
         coef_ff[1] <= '{re: in_ff.re, im: in_ff.im};
         for (int j = 2; j <= W_STAGE; j++) begin
            coef_ff[j] <= coef_ff[j-1];
         end
      end
   end

   // stages 1 to 3: frequency wrap, square, gain multiply
   always_ff @(posedge clock) begin
      if (enable) begin
         mag_r_ff  <= wrap_mag(in_ff.row, image_height_ff);
         mag_c_ff  <= wrap_mag(in_ff.col, image_width_ff);
         sq_r_ff   <= clamp_sq(SQ_FULL'(mag_r_ff) * SQ_FULL'(mag_r_ff));
         sq_c_ff   <= clamp_sq(SQ_FULL'(mag_c_ff) * SQ_FULL'(mag_c_ff));
         prod_r_ff <= GP_BITS'(row_gain_ff) * GP_BITS'(sq_r_ff);
         prod_c_ff <= GP_BITS'(col_gain_ff) * GP_BITS'(sq_c_ff);
      end
   end

   // stage 4: exponent sum and cutoff
   always_comb begin
      x_sum          = (X_BITS+1)'(prod_r_ff[X_BITS-1:0]) + (X_BITS+1)'(prod_c_ff[X_BITS-1:0]);
      exp_in_in.zero = (prod_r_ff >= GP_BITS'(EXP_CUT)) || (prod_c_ff >= GP_BITS'(EXP_CUT)) ||
                       (x_sum >= (X_BITS+1)'(EXP_CUT));
      exp_in_in.x    = x_sum[X_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         exp_in_ff <= exp_in_in;
      end
   end

   // weight from the exp unit
   dgw_exp #(
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_exp (
      .clock  (clock),
      .enable (enable),
      .exp_in (exp_in_ff),
      .weight (weight)
   );

   // sample times weight plus half an lsb
   always_comb begin
      w_ext  = $signed(PROD_BITS'(weight));
      v_r_in = PROD_BITS'(coef_ff[W_STAGE].re) * w_ext +
               $signed(PROD_BITS'(1) << (FRAC - 1));
      v_i_in = PROD_BITS'(coef_ff[W_STAGE].im) * w_ext +
               $signed(PROD_BITS'(1) << (FRAC - 1));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         v_r_ff <= v_r_in;
         v_i_ff <= v_i_in;
      end
   end

   // output register: floor shift back to sample format
   always_ff @(posedge clock) begin
      if (enable && vld_ff[S_STAGE]) begin
         out_real_ff <= SAMPLE_BITS'(v_r_ff >>> FRAC);
         out_imag_ff <= SAMPLE_BITS'(v_i_ff >>> FRAC);
      end
   end

   assign rsp_valid    = vld_ff[O_STAGE];
   assign rsp_out_real = out_real_ff;
   assign rsp_out_imag = out_imag_ff;

endmodule
